>>> design/ise_pkg.sv
// Shared types, codes and constants of the integer stack engine.
`default_nettype none

package ise_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_W          = 32;
    localparam int CMD_W           = 3;
    localparam int ERR_W           = 3;
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 3'd0,
        CMD_DUMP    = 3'd1,
        CMD_PEEK    = 3'd2,
        CMD_POP     = 3'd3,
        CMD_SWAP    = 3'd4,
        CMD_ADD     = 3'd5,
        CMD_NOP     = 3'd6,
        CMD_UNKNOWN = 3'd7
    } t_cmd;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK      = 3'd0,
        ERR_UNKNOWN = 3'd1,
        ERR_USAGE   = 3'd2,
        ERR_FULL    = 3'd3,
        ERR_PEEK    = 3'd4,
        ERR_POP     = 3'd5,
        ERR_SWAP    = 3'd6,
        ERR_ADD     = 3'd7
    } t_err;

    typedef enum logic [2:0] {
        OP_REPORT,
        OP_PUSH,
        OP_DUMP,
        OP_PEEK,
        OP_POP,
        OP_SWAP,
        OP_ADD
    } t_op;

    typedef struct packed {
        t_op               op;
        t_err              err;
        logic [WORD_W-1:0] value;
    } t_work;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              value_valid;
        t_err              err;
        logic              last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PEEK,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SWAP_W,
        ST_ADD_A,
        ST_ADD_B,
        ST_DUMP
    } t_state;

endpackage

`default_nettype wire

>>> design/ise_if.sv
// Request and result channel interfaces of the integer stack engine.
`default_nettype none

interface ise_in_if;
    logic                             valid;
    logic                             ready;
    logic [ise_pkg::CMD_W-1:0]        command;
    logic signed [ise_pkg::WORD_W-1:0] push_value;
    logic                             push_arg_valid;

    modport source (output valid, output command, output push_value,
                    output push_arg_valid, input ready);
    modport sink (input valid, input command, input push_value,
                  input push_arg_valid, output ready);
endinterface

interface ise_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [ise_pkg::WORD_W-1:0] value;
    logic                             value_valid;
    logic [ise_pkg::ERR_W-1:0]        error_code;
    logic                             last;

    modport source (output valid, output value, output value_valid,
                    output error_code, output last, input ready);
    modport sink (input valid, input value, input value_valid,
                  input error_code, input last, output ready);
endinterface

`default_nettype wire

>>> design/integer_stack_engine.sv
// Integer stack engine top level: request front end, queue and execution back end.
//
// Requests arrive on i_cmd (command, push_value, push_arg_valid) and are taken
// whenever the two-entry request queue has room. Results leave on o_res
// (value, value_valid, error_code, last) through an output register, so a new
// request can be taken while a finished result waits for the receiver.
// Every request gives exactly one result, except a dump of a non-empty stack,
// which gives one result per entry, top first, with last set on the bottom one.
// In the back end, push, pop, nop and all error cases are completed in the idle
// state; peek, add, swap and a dump of a non-empty stack step through further
// states, set by the single read port of the stack RAM, whose read data is
// registered. Requests pass through the queue, results through the output register.
// A synchronous active-low reset empties the stack, the queue and the output
// register; stack RAM contents are not cleared. When the receiver stalls, the
// current result is held and the back end waits; the front end keeps taking
// requests until the queue is full.
`default_nettype none

module integer_stack_engine #(
    parameter int STACK_DEPTH = ise_pkg::STACK_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ise_in_if.sink    i_cmd,
    ise_out_if.source o_res
);
    import ise_pkg::*;

    t_work work;
    logic  work_valid;
    logic  work_take;

    ise_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_work       (work),
        .o_work_valid (work_valid),
        .i_work_take  (work_take)
    );

    ise_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (work),
        .i_work_valid (work_valid),
        .o_work_take  (work_take),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

>>> design/ise_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ise_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/ise_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module ise_front (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ise_in_if.sink      i_cmd,
    output ise_pkg::t_work o_work,
    output logic        o_work_valid,
    input  wire logic   i_work_take
);
    import ise_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_work            r_q [QUEUE_DEPTH];
    logic [QPW-1:0]   r_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_fill;
    t_work            cls;
    logic             accept;

    always_comb begin
        cls.op    = OP_REPORT;
        cls.err   = ERR_OK;
        cls.value = i_cmd.push_value;
        unique case (t_cmd'(i_cmd.command))
            CMD_PUSH: begin
                if (i_cmd.push_arg_valid) begin
                    cls.op = OP_PUSH;
                end else begin
                    cls.err = ERR_USAGE;
                end
            end
            CMD_DUMP:    cls.op  = OP_DUMP;
            CMD_PEEK:    cls.op  = OP_PEEK;
            CMD_POP:     cls.op  = OP_POP;
            CMD_SWAP:    cls.op  = OP_SWAP;
            CMD_ADD:     cls.op  = OP_ADD;
            CMD_NOP:     cls.err = ERR_OK;
            CMD_UNKNOWN: cls.err = ERR_UNKNOWN;
            default:     cls.err = ERR_UNKNOWN;
        endcase
    end

    assign i_cmd.ready  = (r_fill != QCW'(QUEUE_DEPTH));
    assign accept       = i_cmd.valid && i_cmd.ready;
    assign o_work_valid = (r_fill != '0);
    assign o_work       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPW'(1);
            end
            if (i_work_take) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPW'(1);
            end
            if (accept && !i_work_take) begin
                r_fill <= r_fill + QCW'(1);
            end else if (!accept && i_work_take) begin
                r_fill <= r_fill - QCW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/ise_back.sv
// Back end: executes queued stack operations against the stack RAM and drives results.
`default_nettype none

module ise_back #(
    parameter int STACK_DEPTH = ise_pkg::STACK_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ise_pkg::t_work i_work,
    input  wire logic           i_work_valid,
    output logic                o_work_take,
    ise_out_if.source           o_res
);
    import ise_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     n_idx;
    logic [WORD_W-1:0] r_tmp;
    logic [WORD_W-1:0] n_tmp;
    t_result           r_out;
    logic              r_out_valid;

    logic              out_free;
    logic              empty;
    logic              short;
    logic              full;
    logic [AW-1:0]     top_addr;
    logic [AW-1:0]     sec_addr;
    logic              ram_we;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              emit;
    t_result           res;

    ise_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign out_free = !r_out_valid || o_res.ready;
    assign empty    = (r_count == '0);
    assign short    = (r_count < CW'(2));
    assign full     = (r_count == CW'(STACK_DEPTH));
    assign top_addr = r_count[AW-1:0] - AW'(1);
    assign sec_addr = top_addr - AW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_work_valid && out_free) begin
                    case (i_work.op)
                        OP_DUMP: if (!empty) n_state = ST_DUMP;
                        OP_PEEK: if (!empty) n_state = ST_PEEK;
                        OP_SWAP: if (!short) n_state = ST_SWAP_A;
                        OP_ADD:  if (!short) n_state = ST_ADD_A;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_PEEK:   if (out_free) n_state = ST_IDLE;
            ST_SWAP_A: n_state = ST_SWAP_B;
            ST_SWAP_B: n_state = ST_SWAP_W;
            ST_SWAP_W: if (out_free) n_state = ST_IDLE;
            ST_ADD_A:  n_state = ST_ADD_B;
            ST_ADD_B:  if (out_free) n_state = ST_IDLE;
            ST_DUMP:   if (out_free && r_idx == '0) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_work_take     = 1'b0;
        ram_we          = 1'b0;
        wr_addr         = top_addr;
        wr_data         = rd_data;
        rd_en           = 1'b0;
        rd_addr         = top_addr;
        emit            = 1'b0;
        res.value       = '0;
        res.value_valid = 1'b0;
        res.err         = ERR_OK;
        res.last        = 1'b1;
        n_count         = r_count;
        n_idx           = r_idx;
        n_tmp           = r_tmp;
        unique case (r_state)
            ST_IDLE: begin
                if (i_work_valid && out_free) begin
                    o_work_take = 1'b1;
                    case (i_work.op)
                        OP_PUSH: begin
                            emit = 1'b1;
                            if (full) begin
                                res.err = ERR_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                wr_addr = r_count[AW-1:0];
                                wr_data = i_work.value;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DUMP: begin
                            if (empty) begin
                                emit = 1'b1;
                            end else begin
                                rd_en = 1'b1;
                                n_idx = top_addr;
                            end
                        end
                        OP_PEEK: begin
                            if (empty) begin
                                emit    = 1'b1;
                                res.err = ERR_PEEK;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        OP_POP: begin
                            emit = 1'b1;
                            if (empty) begin
                                res.err = ERR_POP;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_SWAP: begin
                            if (short) begin
                                emit    = 1'b1;
                                res.err = ERR_SWAP;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        OP_ADD: begin
                            if (short) begin
                                emit    = 1'b1;
                                res.err = ERR_ADD;
                            end else begin
                                rd_en = 1'b1;
                            end
                        end
                        default: begin
                            emit    = 1'b1;
                            res.err = i_work.err;
                        end
                    endcase
                end
            end
            ST_PEEK: begin
                if (out_free) begin
                    emit            = 1'b1;
                    res.value       = rd_data;
                    res.value_valid = 1'b1;
                end
            end
            ST_SWAP_A, ST_ADD_A: begin
                n_tmp   = rd_data;
                rd_en   = 1'b1;
                rd_addr = sec_addr;
            end
            ST_SWAP_B: begin
                ram_we  = 1'b1;
                wr_addr = top_addr;
                wr_data = rd_data;
            end
            ST_SWAP_W: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ram_we  = 1'b1;
                    wr_addr = sec_addr;
                    wr_data = r_tmp;
                end
            end
            ST_ADD_B: begin
                if (out_free) begin
                    emit    = 1'b1;
                    ram_we  = 1'b1;
                    wr_addr = sec_addr;
                    wr_data = rd_data + r_tmp;
                    n_count = r_count - CW'(1);
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    emit            = 1'b1;
                    res.value       = rd_data;
                    res.value_valid = 1'b1;
                    res.last        = (r_idx == '0);
                    if (r_idx != '0) begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx - AW'(1);
                        n_idx   = r_idx - AW'(1);
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_tmp <= n_tmp;
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.value       = r_out.value;
    assign o_res.value_valid = r_out.value_valid;
    assign o_res.error_code  = r_out.err;
    assign o_res.last        = r_out.last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("Entry count exceeds the stack depth.");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count))
            |-> ($past(r_state) == ST_IDLE || $past(r_state) == ST_ADD_B))
        else $error("Entry count changed outside a push, pop or add.");

    a_dump_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP && emit && res.last) |=> (r_state == ST_IDLE))
        else $error("Dump did not end after its bottom entry.");

    a_dump_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state == ST_DUMP && ram_we))
        else $error("Stack RAM written during a dump.");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> out_free)
        else $error("Result issued while the output register is occupied.");

endmodule

`default_nettype wire
